// ----- design/glc_pkg.sv -----
// Shared types and constants for the glyph code lookup block.
package glc_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int CODE_BITS   = 16;
    localparam int INDEX_BITS  = 10;
    localparam int COUNT_BITS  = 11;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ESCAPE_BYTE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT = 1'b1;

    localparam logic [BYTE_BITS-1:0]  ESCAPE_RESET = 8'hFF;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET  = '0;

    // Action codes of an input transaction
    localparam logic ACT_TABLE_WRITE = 1'b0;
    localparam logic ACT_TEXT_BYTE   = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [CODE_BITS-1:0] code;
    } srch_req_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] glyph_index;
        logic                  found;
        logic [CODE_BITS-1:0]  char_code;
    } srch_res_t;

endpackage

// ----- design/glc_table.sv -----
// Code table memory: one write port, one read port with registered data.
module glc_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [glc_pkg::CODE_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [glc_pkg::CODE_BITS-1:0] rd_data
);
    import glc_pkg::*;

    logic [CODE_BITS-1:0] mem [DEPTH];
    logic [CODE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/glc_search.sv -----
// Binary search sequencer: one table probe per cycle over the sorted code table.
module glc_search #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  glc_pkg::srch_req_t            req,
    input  logic [CW-1:0]                 count,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [glc_pkg::CODE_BITS-1:0] rd_data,
    output logic                          idle,
    output logic                          res_valid,
    output glc_pkg::srch_res_t            res,
    input  logic                          res_take
);
    import glc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_DONE  = 3'b100
    } srch_state_t;

    srch_state_t          state_reg, state_next;
    logic [CW-1:0]        left_reg, left_next;
    logic [CW-1:0]        rp1_reg, rp1_next;     // right bound plus one
    logic [AW-1:0]        mid_reg, mid_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        pos_reg, pos_next;

    logic                 probe_eq;
    logic                 probe_lt;
    logic [CW-1:0]        mid_ext;
    logic [CW-1:0]        new_left;
    logic [CW-1:0]        new_rp1;
    logic [CW:0]          mid_sum;
    logic [CW-1:0]        count_m1;

    assign probe_eq = (rd_data == code_reg);
    assign probe_lt = (rd_data < code_reg);
    assign mid_ext  = CW'(mid_reg);
    assign new_left = probe_lt ? (mid_ext + CW'(1)) : left_reg;
    assign new_rp1  = probe_lt ? rp1_reg : mid_ext;
    assign mid_sum  = (CW+1)'(new_left) + (CW+1)'(new_rp1) - (CW+1)'(1);
    assign count_m1 = count - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        rp1_next   = rp1_reg;
        mid_next   = mid_reg;
        code_next  = code_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    code_next  = req.code;
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // first probe at the middle of [0, count-1]
                        left_next  = '0;
                        rp1_next   = count;
                        mid_next   = AW'(count_m1 >> 1);
                        rd_en      = 1'b1;
                        rd_addr    = mid_next;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (probe_eq)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_DONE;
                end
                else if (new_left < new_rp1)
                begin
                    left_next = new_left;
                    rp1_next  = new_rp1;
                    mid_next  = AW'(mid_sum >> 1);
                    rd_en     = 1'b1;
                    rd_addr   = mid_next;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        rp1_reg   <= rp1_next;
        mid_reg   <= mid_next;
        code_reg  <= code_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign idle            = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.glyph_index = INDEX_BITS'(pos_reg);
    assign res.found       = found_reg;
    assign res.char_code   = code_reg;

    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (left_reg < rp1_reg))
        else $error("search probing with an empty interval");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.glyph_index == '0))
        else $error("missed code reported with a nonzero glyph index");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == S_IDLE))
        else $error("search started while busy");

endmodule

// ----- design/glyph_code_lookup_top.sv -----
// Top level of the glyph code lookup: byte parser, configuration and result register.
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per handshake.
//   action = 0 writes entry_code at entry_index of the sorted code table;
//   action = 1 delivers text_byte to the parser. A plain byte is a code, the
//   escape byte announces a 16-bit code sent low byte first, and a zero byte
//   resets the parser. Each complete code is searched over the first
//   entry_count entries and one result transaction leaves on the output
//   channel (out_valid / out_stall) with glyph_index, found and char_code.
//   Table writes and bytes that complete no code start no search.
//   A code is searched with P probes before its result is ready, where
//   P is the probe count: 0 for an empty table, else 1 .. ceil(log2(n + 1))
//   for n entries (up to 11 at 1024); the single read port gives one probe a cycle.
//   The input stalls while a search runs. A finished result moves into the
//   output register, so the next transaction is accepted while it waits.
//   If the receiver stalls with the register full, a finished search holds
//   and the input stays stalled until the register drains.
//   Reset clears the parser, sets escape_byte to 0xFF and entry_count to 0.
//   The table holds no defined contents until written. Write configuration
//   only while the block is idle.
module glyph_code_lookup_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [glc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [glc_pkg::COUNT_BITS-1:0]   cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [glc_pkg::INDEX_BITS-1:0]   entry_index,
    input  logic [glc_pkg::CODE_BITS-1:0]    entry_code,
    input  logic [glc_pkg::BYTE_BITS-1:0]    text_byte,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [glc_pkg::INDEX_BITS-1:0]   glyph_index,
    output logic                             found,
    output logic [glc_pkg::CODE_BITS-1:0]    char_code
);
    import glc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_LOW   = 3'b010,
        PH_HIGH  = 3'b100
    } parse_phase_t;

    // configuration registers
    logic [BYTE_BITS-1:0]  escape_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // parser state
    parse_phase_t          phase_reg, phase_next;
    logic [BYTE_BITS-1:0]  held_low_reg, held_low_next;

    // output register
    logic                  out_valid_reg;
    srch_res_t             out_res_reg;

    logic                  in_accept;
    logic                  byte_accept;
    srch_req_t             srch_req;
    logic [CW-1:0]         srch_count;
    logic                  srch_idle;
    logic                  srch_res_valid;
    srch_res_t             srch_res;
    logic                  srch_res_take;

    logic                  tbl_wr_en;
    logic                  tbl_rd_en;
    logic [AW-1:0]         tbl_rd_addr;
    logic [CODE_BITS-1:0]  tbl_rd_data;

    assign in_stall    = !srch_idle;
    assign in_accept   = in_valid && !in_stall;
    assign byte_accept = in_accept && (action == ACT_TEXT_BYTE);

    // Drop table writes beyond the table depth.
    assign tbl_wr_en = in_accept && (action == ACT_TABLE_WRITE)
                       && (32'(entry_index) < 32'(TABLE_DEPTH));

    // Clamp the entry count to the table depth.
    assign srch_count = (32'(count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= ESCAPE_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ESCAPE_BYTE: escape_reg <= cfg_data[BYTE_BITS-1:0];
                CFG_ENTRY_COUNT: count_reg  <= cfg_data;
                default:         count_reg  <= count_reg;
            endcase
        end
    end

    // Byte parser: assemble codes and launch a search for each complete one.
    always_comb
    begin
        phase_next     = phase_reg;
        held_low_next  = held_low_reg;
        srch_req.start = 1'b0;
        srch_req.code  = {{(CODE_BITS-BYTE_BITS){1'b0}}, text_byte};

        if (byte_accept)
        begin
            if (text_byte == '0)
            begin
                // zero byte: reset the parser, no result
                phase_next    = PH_PLAIN;
                held_low_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        held_low_next = text_byte;
                        phase_next    = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        srch_req.start = 1'b1;
                        srch_req.code  = {text_byte, held_low_reg};
                        phase_next     = PH_PLAIN;
                        held_low_next  = '0;
                    end
                    default:
                    begin
                        if (text_byte == escape_reg)
                        begin
                            phase_next = PH_LOW;
                        end
                        else
                        begin
                            phase_next     = PH_PLAIN;
                            srch_req.start = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PLAIN;
            held_low_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            held_low_reg <= held_low_next;
        end
    end

    glc_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (entry_code),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    glc_search #(
        .DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (srch_req),
        .count     (srch_count),
        .rd_en     (tbl_rd_en),
        .rd_addr   (tbl_rd_addr),
        .rd_data   (tbl_rd_data),
        .idle      (srch_idle),
        .res_valid (srch_res_valid),
        .res       (srch_res),
        .res_take  (srch_res_take)
    );

    // Advance a finished search into the output register when it is free
    // or being drained this cycle.
    assign srch_res_take = srch_res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (srch_res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (srch_res_take)
        begin
            out_res_reg <= srch_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign glyph_index = out_res_reg.glyph_index;
    assign found       = out_res_reg.found;
    assign char_code   = out_res_reg.char_code;

    a_held_clear_in_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PLAIN) |-> (held_low_reg == '0))
        else $error("held low byte not cleared in plain phase");

    a_out_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(srch_res_valid))
        else $error("output transaction without a finished search");

    a_out_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_res_reg)))
        else $error("stalled output transaction changed");

endmodule
